// ===== rtl/core/pps_time_tagger_assert.svh =====
// Assertion macros for the PPS time tagger checks.
`ifndef PPS_TIME_TAGGER_ASSERT_SVH
`define PPS_TIME_TAGGER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PPS_ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pps_time_tagger check failed");

// Check a property on every clock edge, reset included.
`define PPS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pps_time_tagger reset check failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

   localparam int unsigned TIME_W      = 64;
   localparam int unsigned WINDOW_W    = 20;
   localparam int unsigned LIMIT_W     = 8;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned REM_W       = 20;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned TIME_BYTES  = TIME_W / BYTE_W;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [REM_W-1:0]    ONE_SECOND_US     = 20'd1000000;
   localparam logic [WINDOW_W-1:0] RATE_WINDOW_RESET = 20'd50000;
   localparam logic [LIMIT_W-1:0]  FAULT_LIMIT_RESET = 8'd10;
   localparam logic [COUNT_W-1:0]  COUNT_MAX         = 8'hFF;

   typedef enum logic {
      OP_GPS_UPDATE = 1'b0,
      OP_PPS_EDGE   = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RATE_WINDOW = 8'd0,
      CSR_FAULT_LIMIT = 8'd1
   } csr_index_type;

   // One captured edge on its way to the rounding pipeline
   typedef struct packed {
      logic [TIME_W-1:0]  edge_time;
      logic [COUNT_W-1:0] count;
      logic               fault;
      logic [TIME_W-1:0]  estimate;
   } edge_entry_type;

   // Fold one byte into a running remainder modulo one second, bit by bit
   function automatic logic [REM_W-1:0] mod_step_byte(input logic [REM_W-1:0] rem,
                                                      input logic [BYTE_W-1:0] data);
      logic [REM_W:0] acc;
      acc = {1'b0, rem};
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         acc = {acc[REM_W-1:0], data[i]};
         if (acc >= {1'b0, ONE_SECOND_US}) begin
            acc = acc - {1'b0, ONE_SECOND_US};
         end
      end
      return acc[REM_W-1:0];
   endfunction

endpackage

// ===== rtl/core/pps_front.sv =====
module pps_front
   import pps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [TIME_W-1:0]      req_local_time,
   input  logic [TIME_W-1:0]      req_utc_time,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   queue_full,
   output logic                   push,
   output edge_entry_type         push_entry
);

   logic [TIME_W-1:0]   prev_edge_ff, prev_edge_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0]   offset_ff, offset_in;
   logic                disabled_ff, disabled_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;

   logic                accept;
   logic                is_edge;
   logic [TIME_W-1:0]   spacing;
   logic                is_fast;
   logic [COUNT_W-1:0]  count_next;
   logic                fault;

   // Stall only while the queue has no room
   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !queue_full;
   assign is_edge   = (req_op == OP_PPS_EDGE);

   // Classify the edge against the previous one
   always_comb begin
      spacing    = req_local_time - prev_edge_ff;
      is_fast    = (spacing < {{(TIME_W-WINDOW_W){1'b0}}, window_ff});
      count_next = count_ff;
      if (is_fast && (count_ff != COUNT_MAX)) begin
         count_next = count_ff + 1'b1;
      end
      fault = is_fast && (count_next >= limit_ff);
   end

   // Hand accepted edges to the queue unless tagging is disabled
   assign push                = accept && is_edge && !disabled_ff;
   assign push_entry.edge_time = req_local_time;
   assign push_entry.count     = count_next;
   assign push_entry.fault     = fault;
   assign push_entry.estimate  = req_local_time + offset_ff;

   // Advance edge and GPS state, take configuration writes
   always_comb begin
      prev_edge_in = prev_edge_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      disabled_in  = disabled_ff;
      window_in    = window_ff;
      limit_in     = limit_ff;
      if (accept && !is_edge) begin
         offset_in = req_utc_time - req_local_time;
      end
      if (push) begin
         prev_edge_in = req_local_time;
         count_in     = count_next;
         disabled_in  = fault;
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATE_WINDOW: window_in = csr_wdata[WINDOW_W-1:0];
            CSR_FAULT_LIMIT: limit_in  = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_edge_ff <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         disabled_ff  <= 1'b0;
         window_ff    <= RATE_WINDOW_RESET;
         limit_ff     <= FAULT_LIMIT_RESET;
      end else begin
         prev_edge_ff <= prev_edge_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         disabled_ff  <= disabled_in;
         window_ff    <= window_in;
         limit_ff     <= limit_in;
      end
   end

endmodule

// ===== rtl/core/pps_queue.sv =====
module pps_queue
   import pps_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  edge_entry_type push_entry,
   input  logic           pop,
   output edge_entry_type pop_entry,
   output logic           full,
   output logic           nonempty
);

   localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   edge_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == FULL_FILL);
   assign nonempty  = (fill_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count on each transfer
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/pps_back.sv =====
module pps_back
   import pps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_nonempty,
   output logic               pop,
   input  edge_entry_type     pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [TIME_W-1:0]  rsp_edge_time,
   output logic [COUNT_W-1:0] rsp_fast_edge_count,
   output logic [TIME_W-1:0]  rsp_utc_second,
   output logic               rsp_fault_raised
);

   typedef struct packed {
      edge_entry_type   entry;
      logic [REM_W-1:0] rem;
   } stage_type;

   stage_type          stage_ff [TIME_BYTES];
   stage_type          stage_in [TIME_BYTES];
   logic [TIME_BYTES-1:0] valid_ff, valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  edge_time_ff, edge_time_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  utc_ff, utc_in;
   logic               fault_ff, fault_in;

   logic               advance;
   stage_type          last;

   // Move the whole pipeline whenever the output register is empty or being taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = queue_nonempty && advance;
   assign last    = stage_ff[TIME_BYTES-1];

   // One byte of the estimate per stage, most significant first
   always_comb begin
      stage_in[0].entry = pop_entry;
      stage_in[0].rem   = mod_step_byte('0, pop_entry.estimate[TIME_W-1 -: BYTE_W]);
      valid_in[0]       = pop;
      for (int k = 1; k < TIME_BYTES; k++) begin
         stage_in[k].entry = stage_ff[k-1].entry;
         stage_in[k].rem   = mod_step_byte(stage_ff[k-1].rem,
            stage_ff[k-1].entry.estimate[TIME_W - 1 - BYTE_W * k -: BYTE_W]);
         valid_in[k]       = valid_ff[k-1];
      end
   end

   // Floor to the whole second and add one second
   always_comb begin
      rsp_valid_in = valid_ff[TIME_BYTES-1];
      edge_time_in = last.entry.edge_time;
      count_in     = last.entry.count;
      fault_in     = last.entry.fault;
      utc_in       = last.entry.estimate
                   + {{(TIME_W-REM_W){1'b0}}, ONE_SECOND_US - last.rem};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload carries no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < TIME_BYTES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         edge_time_ff <= edge_time_in;
         count_ff     <= count_in;
         utc_ff       <= utc_in;
         fault_ff     <= fault_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_edge_time       = edge_time_ff;
   assign rsp_fast_edge_count = count_ff;
   assign rsp_utc_second      = utc_ff;
   assign rsp_fault_raised    = fault_ff;

endmodule

// ===== rtl/core/pps_time_tagger.sv =====
// An accepted edge passes through the queue, eight remainder stages of one byte each and
// the output register before it shows on rsp_valid.
// Throughput: one item per cycle; the front stalls only when the queue (4 entries by default) is full.
// GPS updates and dropped edges give no result.
// Reset (synchronous, active high) clears all edge and GPS state and the queue,
// and restores rate_window to 50000 and fault_limit to 10.
module pps_time_tagger
   import pps_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [TIME_W-1:0]      req_local_time,
   input  logic [TIME_W-1:0]      req_utc_time,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [TIME_W-1:0]      rsp_edge_time,
   output logic [COUNT_W-1:0]     rsp_fast_edge_count,
   output logic [TIME_W-1:0]      rsp_utc_second,
   output logic                   rsp_fault_raised,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_nonempty;
   edge_entry_type push_entry;
   edge_entry_type pop_entry;

   pps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_local_time (req_local_time),
      .req_utc_time   (req_utc_time),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   pps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .nonempty   (queue_nonempty)
   );

   pps_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_nonempty      (queue_nonempty),
      .pop                 (pop),
      .pop_entry           (pop_entry),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_edge_time       (rsp_edge_time),
      .rsp_fast_edge_count (rsp_fast_edge_count),
      .rsp_utc_second      (rsp_utc_second),
      .rsp_fault_raised    (rsp_fault_raised)
   );

endmodule

// ===== rtl/core/pps_checker.sv =====
`include "pps_time_tagger_assert.svh"

module pps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_edge_time,
   input logic [7:0]  rsp_fast_edge_count,
   input logic [63:0] rsp_utc_second,
   input logic        rsp_fault_raised
);

   logic         fault_seen_ff;
   logic [136:0] rsp_payload;

   // Gather the result fields for the hold check
   assign rsp_payload = {rsp_edge_time, rsp_fast_edge_count, rsp_utc_second, rsp_fault_raised};

   // Remember that the disabling edge has been transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_fault_raised) begin
         fault_seen_ff <= 1'b1;
      end
   end

   `PPS_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid)

   `PPS_ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   `PPS_ASSERT_CLK(a_fault_needs_count, rsp_valid && rsp_fault_raised |-> rsp_fast_edge_count != 8'd0)

   `PPS_ASSERT_CLK(a_silent_after_fault, rsp_valid |-> !fault_seen_ff)

endmodule

bind pps_time_tagger pps_checker u_pps_checker (.*);
